/* sv/ctv_pkg.sv */
package ctv_pkg;

  // Phases of the header value parser, one-hot coded.
  typedef enum logic [7:0] {
    PH_MEDIA       = 8'b0000_0001,
    PH_KEY_LEAD    = 8'b0000_0010,
    PH_KEY         = 8'b0000_0100,
    PH_VAL_LEAD    = 8'b0000_1000,
    PH_VAL_PLAIN   = 8'b0001_0000,
    PH_VAL_QUOTED  = 8'b0010_0000,
    PH_AFTER_QUOTE = 8'b0100_0000,
    PH_FAIL        = 8'b1000_0000
  } phase_e;

  localparam int unsigned NumMedia = 7;
  localparam int unsigned NumVal   = 2;
  localparam int unsigned StrBits  = 8 * 24;

  typedef logic [StrBits-1:0] str_t;

  // Candidate strings, right-aligned in a fixed-width word.
  localparam str_t MediaStr [NumMedia] = '{
    str_t'("text/html"), str_t'("image/png"), str_t'("image/jpeg"),
    str_t'("image/gif"), str_t'("image/bmp"), str_t'("image/x-ms-bmp"),
    str_t'("application/octet-stream")
  };
  localparam int unsigned MediaLen [NumMedia] = '{9, 9, 10, 9, 9, 14, 24};

  localparam str_t ValStr [NumVal] = '{str_t'("utf-8"), str_t'("us-ascii")};
  localparam int unsigned ValLen [NumVal] = '{5, 8};

  localparam str_t        KeyStr = str_t'("charset");
  localparam int unsigned KeyLen = 7;

  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  typedef logic [4:0] pos_t;
  localparam pos_t PosMax = 5'd31;

  // Character of a string at a position; zero past its end.
  function automatic logic [7:0] str_char(str_t s, int unsigned len, pos_t pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(pos) < len) begin
      ch = s[8*(len-1-int'(pos)) +: 8];
    end
    return ch;
  endfunction

  // Lower-case folding of ASCII letters.
  function automatic logic [7:0] fold(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [NumMedia-1:0] media_hit(logic [7:0] fc, pos_t pos);
    logic [NumMedia-1:0] h;
    for (int i = 0; i < NumMedia; i++) begin
      h[i] = (fc == str_char(MediaStr[i], MediaLen[i], pos));
    end
    return h;
  endfunction

  function automatic logic [NumMedia-1:0] media_end(pos_t pos);
    logic [NumMedia-1:0] h;
    for (int i = 0; i < NumMedia; i++) begin
      h[i] = (int'(pos) == MediaLen[i]);
    end
    return h;
  endfunction

  function automatic logic [NumVal-1:0] val_hit(logic [7:0] fc, pos_t pos);
    logic [NumVal-1:0] h;
    for (int i = 0; i < NumVal; i++) begin
      h[i] = (fc == str_char(ValStr[i], ValLen[i], pos));
    end
    return h;
  endfunction

  function automatic logic [NumVal-1:0] val_end(pos_t pos);
    logic [NumVal-1:0] h;
    for (int i = 0; i < NumVal; i++) begin
      h[i] = (int'(pos) == ValLen[i]);
    end
    return h;
  endfunction

endpackage

/* sv/content_type_validator.sv */
// Content-Type checker. Header value bytes enter one per request on the input
// channel; a zero byte ends the value and produces exactly one output request
// carrying supported_o, after which the parser starts fresh. Other bytes produce
// no output. With image_mode_i set on the terminating byte, the media type must
// be one of the image or octet-stream types; otherwise it must be text/html with
// well-formed parameters and at most one charset of utf-8 or us-ascii. An empty
// value is accepted. The block takes one byte per cycle: each byte is captured
// in an input register and parsed by one pass of small compare logic, and the
// verdict of a zero byte is written to an output register as the byte leaves the
// input register. Only a zero byte can wait, and only while an earlier verdict
// is still stalled in the output register.
module content_type_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] character_i,
  input  logic       image_mode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       supported_o
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] char_q;
  logic       mode_q;

  // Parser state.
  ctv_pkg::phase_e             phase_q, phase_d;
  ctv_pkg::pos_t               pos_q, pos_d;
  logic [ctv_pkg::NumMedia-1:0] mask_q, mask_d;
  logic                        pend_q, pend_d;
  logic                        key_cs_q, key_cs_d;
  logic                        cs_seen_q, cs_seen_d;
  logic                        start_q, start_d;

  // Output register.
  logic out_valid_q;
  logic supported_q;

  logic is_end, out_free, go, in_acc;
  logic blank, semi, eq, quote;
  logic [7:0] fc;
  logic lead;
  ctv_pkg::pos_t scan_pos, pos_inc;
  logic scan_pend;
  logic [ctv_pkg::NumMedia-1:0] m_hit, m_close_vec;
  logic [1:0] media_close;
  logic [ctv_pkg::NumVal-1:0] v_mask, v_hit, v_step, v_fin;
  logic close_ok, key_hit;
  logic end_ok, verdict;

  // Handshake: nonzero bytes always proceed, a zero byte needs the output slot.
  assign is_end   = (char_q == 8'h00);
  assign out_free = !out_valid_q || !out_stall_i;
  assign go       = in_valid_q && (!is_end || out_free);
  assign in_stall_o = in_valid_q && !go;
  assign in_acc   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q <= character_i;
      mode_q <= image_mode_i;
    end
  end

  // Byte classification and candidate comparisons.
  assign fc    = ctv_pkg::fold(char_q);
  assign blank = (char_q == ctv_pkg::ChSpace) || (char_q == ctv_pkg::ChTab);
  assign semi  = (char_q == ctv_pkg::ChSemi);
  assign eq    = (char_q == ctv_pkg::ChEq);
  assign quote = (char_q == ctv_pkg::ChQuote);

  // Lead phases start a new token at position zero.
  assign lead      = (phase_q == ctv_pkg::PH_KEY_LEAD) || (phase_q == ctv_pkg::PH_VAL_LEAD);
  assign scan_pos  = lead ? '0 : pos_q;
  assign scan_pend = lead ? 1'b0 : pend_q;
  assign pos_inc   = (scan_pos == ctv_pkg::PosMax) ? scan_pos : scan_pos + 5'd1;

  assign m_hit       = ctv_pkg::media_hit(fc, scan_pos);
  assign m_close_vec = mask_q & ctv_pkg::media_end(pos_q);
  assign media_close = {|m_close_vec[ctv_pkg::NumMedia-1:1], m_close_vec[0]};

  assign v_mask = (phase_q == ctv_pkg::PH_VAL_LEAD) ? 2'b11 : mask_q[3:2];
  assign v_hit  = ctv_pkg::val_hit(fc, scan_pos);
  assign v_step = scan_pend ? 2'b00 : (v_mask & v_hit);
  assign v_fin  = v_mask & ctv_pkg::val_end(scan_pos);
  assign close_ok = !key_cs_q || (!cs_seen_q && (|v_fin));

  assign key_hit = (fc == ctv_pkg::str_char(ctv_pkg::KeyStr, ctv_pkg::KeyLen, scan_pos));

  // Verdict for a terminating zero byte.
  always_comb begin
    end_ok = 1'b0;
    unique case (phase_q)
      ctv_pkg::PH_MEDIA:       end_ok = 1'b1;
      ctv_pkg::PH_VAL_LEAD:    end_ok = !key_cs_q;
      ctv_pkg::PH_VAL_PLAIN:   end_ok = close_ok;
      ctv_pkg::PH_AFTER_QUOTE: end_ok = 1'b1;
      default:                 end_ok = 1'b0;
    endcase
    if (start_q) begin
      verdict = 1'b1;
    end else if (mode_q) begin
      verdict = (phase_q == ctv_pkg::PH_MEDIA) ? media_close[1] : mask_q[1];
    end else begin
      verdict = ((phase_q == ctv_pkg::PH_MEDIA) ? media_close[0] : mask_q[0]) && end_ok;
    end
  end

  // Next parser state for a nonzero byte.
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    mask_d    = mask_q;
    pend_d    = pend_q;
    key_cs_d  = key_cs_q;
    cs_seen_d = cs_seen_q;
    start_d   = 1'b0;
    unique case (phase_q)
      ctv_pkg::PH_MEDIA: begin
        if (semi) begin
          mask_d  = {5'b0, media_close};
          pos_d   = '0;
          pend_d  = 1'b0;
          phase_d = ctv_pkg::PH_KEY_LEAD;
        end else if (blank) begin
          pend_d = 1'b1;
        end else begin
          mask_d = pend_q ? '0 : (mask_q & m_hit);
          pos_d  = pos_inc;
        end
      end
      ctv_pkg::PH_KEY_LEAD: begin
        if (blank) begin
          phase_d = phase_q;
        end else if (eq) begin
          key_cs_d = 1'b0;
          phase_d  = ctv_pkg::PH_VAL_LEAD;
        end else if (semi) begin
          phase_d = ctv_pkg::PH_FAIL;
        end else begin
          pend_d   = 1'b0;
          pos_d    = pos_inc;
          key_cs_d = key_hit;
          phase_d  = ctv_pkg::PH_KEY;
        end
      end
      ctv_pkg::PH_KEY: begin
        if (eq) begin
          key_cs_d = key_cs_q && (pos_q == 5'(ctv_pkg::KeyLen));
          phase_d  = ctv_pkg::PH_VAL_LEAD;
        end else if (semi) begin
          phase_d = ctv_pkg::PH_FAIL;
        end else if (blank) begin
          pend_d = 1'b1;
        end else begin
          key_cs_d = !pend_q && key_cs_q && key_hit;
          pos_d    = pos_inc;
        end
      end
      ctv_pkg::PH_VAL_LEAD: begin
        if (!blank) begin
          pend_d = 1'b0;
          if (quote) begin
            mask_d[3:2] = 2'b11;
            pos_d       = '0;
            phase_d     = ctv_pkg::PH_VAL_QUOTED;
          end else if (semi) begin
            mask_d[3:2] = 2'b00;
            pos_d       = '0;
            cs_seen_d   = cs_seen_q || key_cs_q;
            phase_d     = close_ok ? ctv_pkg::PH_KEY_LEAD : ctv_pkg::PH_FAIL;
          end else begin
            mask_d[3:2] = v_step;
            pos_d       = pos_inc;
            phase_d     = ctv_pkg::PH_VAL_PLAIN;
          end
        end
      end
      ctv_pkg::PH_VAL_PLAIN: begin
        if (semi) begin
          mask_d[3:2] = 2'b00;
          cs_seen_d   = cs_seen_q || key_cs_q;
          phase_d     = close_ok ? ctv_pkg::PH_KEY_LEAD : ctv_pkg::PH_FAIL;
        end else if (blank) begin
          pend_d = 1'b1;
        end else begin
          mask_d[3:2] = v_step;
          pos_d       = pos_inc;
        end
      end
      ctv_pkg::PH_VAL_QUOTED: begin
        if (quote) begin
          mask_d[3:2] = 2'b00;
          cs_seen_d   = cs_seen_q || key_cs_q;
          phase_d     = close_ok ? ctv_pkg::PH_AFTER_QUOTE : ctv_pkg::PH_FAIL;
        end else begin
          mask_d[3:2] = v_step;
          pos_d       = pos_inc;
        end
      end
      ctv_pkg::PH_AFTER_QUOTE: begin
        if (!blank) begin
          phase_d = semi ? ctv_pkg::PH_KEY_LEAD : ctv_pkg::PH_FAIL;
        end
      end
      default: begin
        phase_d = ctv_pkg::PH_FAIL;
      end
    endcase
  end

  // Parser state registers; a zero byte returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ctv_pkg::PH_MEDIA;
      pos_q     <= '0;
      mask_q    <= '1;
      pend_q    <= 1'b0;
      key_cs_q  <= 1'b0;
      cs_seen_q <= 1'b0;
      start_q   <= 1'b1;
    end else if (go) begin
      if (is_end) begin
        phase_q   <= ctv_pkg::PH_MEDIA;
        pos_q     <= '0;
        mask_q    <= '1;
        pend_q    <= 1'b0;
        key_cs_q  <= 1'b0;
        cs_seen_q <= 1'b0;
        start_q   <= 1'b1;
      end else begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        mask_q    <= mask_d;
        pend_q    <= pend_d;
        key_cs_q  <= key_cs_d;
        cs_seen_q <= cs_seen_d;
        start_q   <= start_d;
      end
    end
  end

  // Output register holding the verdict until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && is_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && is_end) begin
      supported_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign supported_o = supported_q;

endmodule

/* sv/ctv_checker.sv */
module ctv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] character_i,
  input logic       image_mode_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       supported_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled verdict stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(supported_o))
    else $error("stalled verdict changed");

  // A nonzero byte never holds up the byte that follows it.
  a_byte_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && character_i != 8'h00 |=> !in_stall_o)
    else $error("nonzero byte caused a stall");

  // A terminating byte with a free output slot yields a verdict.
  a_end_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && character_i == 8'h00) ##1 !out_stall_i
      |=> out_valid_o)
    else $error("terminating byte gave no verdict");

  // A new verdict only follows a terminating byte.
  a_verdict_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc && character_i == 8'h00, 2))
    else $error("verdict without terminating byte");

endmodule

bind content_type_validator ctv_checker u_ctv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .character_i  (character_i),
  .image_mode_i (image_mode_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .supported_o  (supported_o)
);

/* tb/sv/ctv_verdict_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the content type validator, keeps its own copy of
// the parser state, and compares every verdict with the oldest one predicted.
module ctv_verdict_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] character_i,
  input  logic       image_mode_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       supported_i,
  output int         err_count_o,
  output int         pending_o
);

  localparam logic [4:0] TokPosMax = 5'd31;
  localparam int         CharsetLen = 7;

  // Mirror of the parser state.
  ctv_pkg::phase_e hdr_phase;
  logic [4:0] tok_pos;
  logic [6:0] cand;
  logic       pend_blank;
  logic       key_charset;
  logic       charset_used;
  logic       at_start;

  // Verdicts predicted but not yet seen on the output.
  logic       verdict_q[$];
  logic       want;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == ctv_pkg::ChSpace || c == ctv_pkg::ChTab;
  endfunction

  // Media types; bit 0 of the candidate mask is the html document type.
  function automatic string media_name(int i);
    case (i)
      0: return "text/html";
      1: return "image/png";
      2: return "image/jpeg";
      3: return "image/gif";
      4: return "image/bmp";
      5: return "image/x-ms-bmp";
      default: return "application/octet-stream";
    endcase
  endfunction

  function automatic string charset_name(int i);
    return (i == 0) ? "utf-8" : "us-ascii";
  endfunction

  // True when the byte matches the name at the current position.
  function automatic logic fits(string s, logic [4:0] pos, logic [7:0] c);
    logic [7:0] ch;
    if (int'(pos) >= s.len()) begin
      return 1'b0;
    end
    ch = s[pos];
    return to_lower(c) == ch;
  endfunction

  function automatic void clear_parser();
    hdr_phase    = ctv_pkg::PH_MEDIA;
    tok_pos      = '0;
    cand         = '1;
    pend_blank   = 1'b0;
    key_charset  = 1'b0;
    charset_used = 1'b0;
    at_start     = 1'b1;
  endfunction

  function automatic void new_token();
    tok_pos    = '0;
    pend_blank = 1'b0;
  endfunction

  // The position stops past the longest name.
  function automatic void step_pos();
    if (tok_pos != TokPosMax) begin
      tok_pos = tok_pos + 5'd1;
    end
  endfunction

  function automatic void media_byte(logic [7:0] c);
    for (int i = 0; i < 7; i++) begin
      if (pend_blank || !fits(media_name(i), tok_pos, c)) begin
        cand[i] = 1'b0;
      end
    end
    step_pos();
  endfunction

  // Ends the media type: bit 0 keeps html, bit 1 says some image type matched.
  function automatic void media_done();
    logic [6:0] m;
    string      s;
    m = cand;
    for (int i = 0; i < 7; i++) begin
      s = media_name(i);
      if (s.len() != int'(tok_pos)) begin
        m[i] = 1'b0;
      end
    end
    cand = {5'b0, |m[6:1], m[0]};
  endfunction

  function automatic void key_byte(logic [7:0] c);
    if (pend_blank || !fits("charset", tok_pos, c)) begin
      key_charset = 1'b0;
    end
    step_pos();
  endfunction

  function automatic void value_start();
    cand[3:2] = 2'b11;
    new_token();
  endfunction

  function automatic void value_byte(logic [7:0] c);
    for (int i = 0; i < 2; i++) begin
      if (pend_blank || !fits(charset_name(i), tok_pos, c)) begin
        cand[2+i] = 1'b0;
      end
    end
    step_pos();
  endfunction

  // Ends a parameter value; a charset must be known and given only once.
  function automatic logic value_done();
    logic [1:0] v;
    logic       ok;
    string      s;
    v = cand[3:2];
    for (int i = 0; i < 2; i++) begin
      s = charset_name(i);
      if (s.len() != int'(tok_pos)) begin
        v[i] = 1'b0;
      end
    end
    cand[6:2] = '0;
    ok = 1'b1;
    if (key_charset) begin
      if (charset_used || v == 2'b00) begin
        ok = 1'b0;
      end
      charset_used = 1'b1;
    end
    return ok;
  endfunction

  // Advances the parser by one accepted byte.
  function automatic void predict_byte(logic [7:0] c, logic img);
    logic [1:0] media;
    logic       ok;
    // A zero byte ends the value and gives the verdict.
    if (c == '0) begin
      media = cand[1:0];
      ok    = 1'b0;
      case (hdr_phase)
        ctv_pkg::PH_MEDIA: begin
          media_done();
          media = cand[1:0];
          ok    = 1'b1;
        end
        ctv_pkg::PH_VAL_LEAD: begin
          value_start();
          ok = value_done();
        end
        ctv_pkg::PH_VAL_PLAIN:   ok = value_done();
        ctv_pkg::PH_AFTER_QUOTE: ok = 1'b1;
        default:                 ok = 1'b0;
      endcase
      if (at_start) begin
        verdict_q.push_back(1'b1);
      end else if (img) begin
        verdict_q.push_back(media[1]);
      end else begin
        verdict_q.push_back(media[0] && ok);
      end
      clear_parser();
      return;
    end
    at_start = 1'b0;
    case (hdr_phase)
      ctv_pkg::PH_MEDIA: begin
        if (c == ctv_pkg::ChSemi) begin
          media_done();
          new_token();
          hdr_phase = ctv_pkg::PH_KEY_LEAD;
        end else if (is_blank(c)) begin
          pend_blank = 1'b1;
        end else begin
          media_byte(c);
        end
      end
      ctv_pkg::PH_KEY_LEAD: begin
        if (is_blank(c)) begin
        end else if (c == ctv_pkg::ChEq) begin
          key_charset = 1'b0;
          hdr_phase   = ctv_pkg::PH_VAL_LEAD;
        end else if (c == ctv_pkg::ChSemi) begin
          hdr_phase = ctv_pkg::PH_FAIL;
        end else begin
          new_token();
          key_charset = 1'b1;
          key_byte(c);
          hdr_phase = ctv_pkg::PH_KEY;
        end
      end
      ctv_pkg::PH_KEY: begin
        if (c == ctv_pkg::ChEq) begin
          key_charset = key_charset && (int'(tok_pos) == CharsetLen);
          hdr_phase   = ctv_pkg::PH_VAL_LEAD;
        end else if (c == ctv_pkg::ChSemi) begin
          hdr_phase = ctv_pkg::PH_FAIL;
        end else if (is_blank(c)) begin
          pend_blank = 1'b1;
        end else begin
          key_byte(c);
        end
      end
      ctv_pkg::PH_VAL_LEAD: begin
        if (!is_blank(c)) begin
          value_start();
          if (c == ctv_pkg::ChQuote) begin
            hdr_phase = ctv_pkg::PH_VAL_QUOTED;
          end else if (c == ctv_pkg::ChSemi) begin
            hdr_phase = value_done() ? ctv_pkg::PH_KEY_LEAD : ctv_pkg::PH_FAIL;
          end else begin
            value_byte(c);
            hdr_phase = ctv_pkg::PH_VAL_PLAIN;
          end
        end
      end
      ctv_pkg::PH_VAL_PLAIN: begin
        if (c == ctv_pkg::ChSemi) begin
          hdr_phase = value_done() ? ctv_pkg::PH_KEY_LEAD : ctv_pkg::PH_FAIL;
        end else if (is_blank(c)) begin
          pend_blank = 1'b1;
        end else begin
          value_byte(c);
        end
      end
      ctv_pkg::PH_VAL_QUOTED: begin
        if (c == ctv_pkg::ChQuote) begin
          hdr_phase = value_done() ? ctv_pkg::PH_AFTER_QUOTE : ctv_pkg::PH_FAIL;
        end else begin
          value_byte(c);
        end
      end
      ctv_pkg::PH_AFTER_QUOTE: begin
        if (!is_blank(c)) begin
          hdr_phase = (c == ctv_pkg::ChSemi) ? ctv_pkg::PH_KEY_LEAD : ctv_pkg::PH_FAIL;
        end
      end
      default: hdr_phase = ctv_pkg::PH_FAIL;
    endcase
  endfunction

  // Predict on every accepted input request, compare every accepted output request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      verdict_q.delete();
      err_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_byte(character_i, image_mode_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          err_count_o++;
          $error("supported: no verdict expected, actual %0d", supported_i);
        end else begin
          want = verdict_q.pop_front();
          if (want !== supported_i) begin
            err_count_o++;
            $error("supported: expected %0d, actual %0d", want, supported_i);
          end
        end
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

// Sends header values byte by byte into the validator and lets the checker
// judge every verdict.
module tb;

  localparam logic [7:0] ChEnd      = 8'h00;
  localparam int         HoldCycles = 80;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [7:0] character_i  = 8'h00;
  logic       image_mode_i = 1'b0;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       supported_o;

  int         err_count;
  int         pending;

  // Bytes of the header value being built.
  logic [7:0] hdr_bytes[$];
  int         bytes_sent  = 0;
  int         values_sent = 0;
  bit         idle_en     = 1'b1;
  bit         long_hold   = 1'b0;

  content_type_validator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .character_i (character_i),
    .image_mode_i(image_mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .supported_o (supported_o)
  );

  ctv_verdict_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .character_i (character_i),
    .image_mode_i(image_mode_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .supported_i (supported_o),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic string media_text(int i);
    case (i)
      0: return "text/html";
      1: return "image/png";
      2: return "image/jpeg";
      3: return "image/gif";
      4: return "image/bmp";
      5: return "image/x-ms-bmp";
      default: return "application/octet-stream";
    endcase
  endfunction

  function automatic void push_char(logic [7:0] c);
    hdr_bytes.push_back(c);
  endfunction

  function automatic void push_blank();
    push_char($urandom_range(0, 1) ? ctv_pkg::ChSpace : ctv_pkg::ChTab);
  endfunction

  function automatic void push_blanks(int max_n);
    repeat ($urandom_range(0, max_n)) push_blank();
  endfunction

  // Pushes a name, sometimes with letters in upper case.
  function automatic void push_text(string s);
    logic [7:0] ch;
    bit         mix;
    mix = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (mix && ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 1)) begin
        ch = ch - 8'h20;
      end
      hdr_bytes.push_back(ch);
    end
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] ch;
    ch = 8'($urandom_range(8'h61, 8'h7A));
    return ch;
  endfunction

  // A token of letters, digits and a few punctuation marks.
  function automatic void push_word(int n);
    logic [7:0] ch;
    string      marks;
    marks = "-/._+";
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: ch = rand_letter();
        1: ch = rand_letter() - 8'h20;
        2: ch = 8'($urandom_range(8'h30, 8'h39));
        default: ch = marks[$urandom_range(0, 4)];
      endcase
      hdr_bytes.push_back(ch);
    end
  endfunction

  // Media type: mostly exact names, sometimes damaged, split, overlong, truncated or random.
  task automatic add_media(output logic img);
    string s;
    int    pick;
    int    k;
    pick = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
    s    = media_text(pick);
    img  = (pick != 0);
    if ($urandom_range(0, 6) == 0) begin
      img = !img;
    end
    case ($urandom_range(0, 9))
      0: push_word($urandom_range(1, 12));
      1: begin
        push_text(s);
        hdr_bytes[hdr_bytes.size() - 1 - $urandom_range(0, s.len() - 1)] = rand_letter();
      end
      2: begin
        push_text(s);
        push_word($urandom_range(20, 30));
      end
      3: begin
        k = $urandom_range(1, s.len() - 1);
        push_text(s.substr(0, k - 1));
        push_blank();
        push_text(s.substr(k, s.len() - 1));
      end
      4: push_text(s.substr(0, s.len() - 2));
      default: push_text(s);
    endcase
  endtask

  // One parameter: key, equals sign and a plain or quoted value, with faults.
  task automatic add_param();
    string s;
    int    kk;
    push_char(ctv_pkg::ChSemi);
    // Empty parameter.
    if ($urandom_range(0, 14) == 0) begin
      return;
    end
    push_blanks(2);
    kk = $urandom_range(0, 9);
    if (kk < 5) begin
      push_text("charset");
    end else if (kk < 8) begin
      push_word($urandom_range(1, 8));
    end else if (kk == 9) begin
      push_text("char");
      push_blank();
      push_text("set");
    end
    if ($urandom_range(0, 3) == 0) begin
      push_blanks(2);
    end
    // Missing equals sign.
    if ($urandom_range(0, 11) == 0) begin
      return;
    end
    push_char(ctv_pkg::ChEq);
    push_blanks(2);
    s = $urandom_range(0, 1) ? "utf-8" : "us-ascii";
    case ($urandom_range(0, 11))
      0, 1, 2, 3: push_text(s);
      4: push_word($urandom_range(1, 10));
      5: ;
      6: begin
        push_char(ctv_pkg::ChQuote);
        push_blanks(1);
        push_text(s);
        push_char(ctv_pkg::ChQuote);
      end
      7: begin
        push_char(ctv_pkg::ChQuote);
        push_word($urandom_range(0, 4));
        push_char($urandom_range(0, 1) ? ctv_pkg::ChSemi : ctv_pkg::ChSpace);
        push_word($urandom_range(0, 4));
        push_char(ctv_pkg::ChQuote);
      end
      8: begin
        push_char(ctv_pkg::ChQuote);
        push_text(s);
      end
      9: begin
        push_char(ctv_pkg::ChQuote);
        push_text(s);
        push_char(ctv_pkg::ChQuote);
        push_blanks(1);
        push_word($urandom_range(1, 3));
      end
      10: begin
        push_text(s);
        void'(hdr_bytes.pop_back());
      end
      default: begin
        push_text(s.substr(0, 1));
        push_blank();
        push_text(s.substr(2, s.len() - 1));
      end
    endcase
    push_blanks(1);
  endtask

  // Builds the next header value; img is the mode for its terminating byte.
  task automatic build_value(output logic img);
    logic [7:0] ch;
    int         n;
    hdr_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      // Arbitrary bytes, long enough at times to saturate the position.
      repeat ($urandom_range(1, 40)) begin
        ch = 8'($urandom_range(1, 255));
        hdr_bytes.push_back(ch);
      end
      img = 1'($urandom_range(0, 1));
    end else begin
      add_media(img);
      push_blanks(2);
      n = img ? $urandom_range(0, 2) : $urandom_range(0, 3);
      repeat (n) add_param();
      if ($urandom_range(0, 14) == 0) begin
        push_char(ctv_pkg::ChSemi);
      end
    end
  endtask

  // Offers one byte and waits until the request is taken.
  task automatic offer_byte(logic [7:0] c, logic img);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    character_i  <= c;
    image_mode_i <= img;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Sends the built value; only the terminating byte's mode matters.
  task automatic send_value(logic img);
    foreach (hdr_bytes[i]) begin
      offer_byte(hdr_bytes[i], 1'($urandom_range(0, 1)));
    end
    offer_byte(ChEnd, img);
    bytes_sent  += hdr_bytes.size() + 1;
    values_sent += 1;
  endtask

  // Pauses the sender until every verdict has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Output stalls: short random bursts, and one long hold on request.
  initial begin : sink_ctrl
    int span;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        span = $urandom_range(1, 5);
        repeat (span) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic img;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed values: empty, exact html, a lone top byte, an image type.
    hdr_bytes.delete();
    send_value(1'b1);
    push_text("text/html");
    send_value(1'b0);
    hdr_bytes.delete();
    push_char(8'hFF);
    send_value(1'b1);
    hdr_bytes.delete();
    push_text("image/png");
    send_value(1'b1);

    // Hold the output off while short values keep coming, then let it drain.
    long_hold = 1'b1;
    repeat (6) begin
      hdr_bytes.delete();
      if ($urandom_range(0, 1)) begin
        push_text("text/html");
      end
      send_value(1'b0);
    end
    drain();

    // Random values, with an occasional full drain.
    while (bytes_sent < 450) begin
      build_value(img);
      send_value(img);
      if ($urandom_range(0, 19) == 0) begin
        drain();
      end
    end

    // Last stretch runs at full rate on both sides.
    idle_en = 1'b0;
    repeat (8) begin
      build_value(img);
      send_value(img);
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
